/* rtl/nlfq_pkg.sv */
// ----------------------------------------------------------------------------
// nlfq_pkg
// Shared types, codes and constants of the NMEA line filter queue.
// ----------------------------------------------------------------------------
package nlfq_pkg;

	localparam int LINE_SIZE_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 8;

	// widest ring position the command queue must carry (QUEUE_DEPTH up to 64)
	localparam int SLOT_MAX_W = 6;

	// input operations
	localparam logic OP_RX  = 1'b0;
	localparam logic OP_POP = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_TAKEN     = 2'd0;
	localparam logic [1:0] KIND_REFUSED   = 2'd1;
	localparam logic [1:0] KIND_LINE_BYTE = 2'd2;
	localparam logic [1:0] KIND_EMPTY     = 2'd3;

	// line events for taken bytes
	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_QUEUED   = 2'd1;
	localparam logic [1:0] EV_FILTERED = 2'd2;
	localparam logic [1:0] EV_EMPTY    = 2'd3;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;

	// first tag character sits at this line position
	localparam int TAG_POS = 3;

	localparam int SKIP_TAG_COUNT = 5;
	localparam logic [31:0] SKIP_TAGS [SKIP_TAG_COUNT] = '{
		"GSV,", "GSA,", "GST,", "MSS,", "ROT,"
	};

	// one request handed from the front to the back
	typedef struct packed {
		logic                  stream;     // stream a queued line, else one result
		logic [1:0]            kind;
		logic [1:0]            line_event;
		logic [SLOT_MAX_W-1:0] slot;
	} cmd_t;

	function automatic logic is_skip_tag(input logic [31:0] tag);
		logic hit;
		hit = 1'b0;
		for (int t = 0; t < SKIP_TAG_COUNT; t++) begin
			if (tag == SKIP_TAGS[t]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

/* rtl/nlfq_ram.sv */
// ----------------------------------------------------------------------------
// nlfq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/nlfq_front.sv */
// ----------------------------------------------------------------------------
// nlfq_front
// Accepts bytes and pop requests, assembles lines straight into the ring
// memory, applies the tag filter and queues one request per item.
// ----------------------------------------------------------------------------
module nlfq_front import nlfq_pkg::*; #(
	parameter int LINE_SIZE   = LINE_SIZE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SW = $clog2(QUEUE_DEPTH),
	localparam int LW = $clog2(LINE_SIZE),
	localparam int AW = $clog2(QUEUE_DEPTH * LINE_SIZE),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [7:0]    rx_byte,
	input  logic          cmd_full,
	output logic          cmd_push,
	output cmd_t          cmd_data,
	input  logic          stream_done,
	output logic          data_we,
	output logic [AW-1:0] data_waddr,
	output logic [7:0]    data_wdata,
	output logic          len_we,
	output logic [SW-1:0] len_waddr,
	output logic [LW-1:0] len_wdata
);

	logic [LW-1:0] len_q;
	logic [SW-1:0] wr_slot_q;
	logic [SW-1:0] rd_slot_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] draining_q;
	logic [7:0]    tag_q [4];

	logic          accept;
	logic          full;
	logic          slot_busy;
	logic          line_end;
	logic          filtered;
	logic [CW:0]   held;
	logic [SW-1:0] wr_slot_next;
	logic [SW-1:0] rd_slot_next;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign held = {1'b0, count_q} + {1'b0, draining_q};
	// the write slot may still be streaming out a popped line
	assign slot_busy = !full && (held >= (CW + 1)'(QUEUE_DEPTH));

	assign in_ready = !cmd_full && !slot_busy;
	assign accept   = in_valid && in_ready;

	assign line_end = (rx_byte == CHAR_NUL) || (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)
		|| (len_q == LW'(LINE_SIZE - 1));
	// tag characters count only once the line holds all of them
	assign filtered = (len_q >= LW'(TAG_POS + 4))
		&& is_skip_tag({tag_q[0], tag_q[1], tag_q[2], tag_q[3]});

	assign wr_slot_next = (wr_slot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
	assign rd_slot_next = (rd_slot_q == SW'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_q + 1'b1;

	assign data_waddr = AW'(wr_slot_q) * AW'(LINE_SIZE) + AW'(len_q);
	assign data_wdata = rx_byte;
	assign len_waddr  = wr_slot_q;
	assign len_wdata  = len_q;

	always_comb begin
		cmd_push            = accept;
		cmd_data.stream     = 1'b0;
		cmd_data.kind       = KIND_TAKEN;
		cmd_data.line_event = EV_NONE;
		cmd_data.slot       = SLOT_MAX_W'(rd_slot_q);
		data_we             = 1'b0;
		len_we              = 1'b0;
		if (op == OP_RX) begin
			if (full) begin
				cmd_data.kind = KIND_REFUSED;
			end else if (line_end) begin
				if (len_q == '0) begin
					cmd_data.line_event = EV_EMPTY;
				end else if (filtered) begin
					cmd_data.line_event = EV_FILTERED;
				end else begin
					cmd_data.line_event = EV_QUEUED;
					len_we              = accept;
				end
			end else begin
				data_we = accept;
			end
		end else begin
			if (count_q == '0) begin
				cmd_data.kind = KIND_EMPTY;
			end else begin
				cmd_data.kind   = KIND_LINE_BYTE;
				cmd_data.stream = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			count_q    <= '0;
			draining_q <= '0;
		end else begin
			logic [CW-1:0] drain_n;
			drain_n = draining_q - CW'(stream_done);
			if (accept && op == OP_RX && !full) begin
				if (line_end) begin
					len_q <= '0;
					if (len_q != '0 && !filtered) begin
						wr_slot_q <= wr_slot_next;
						count_q   <= count_q + 1'b1;
					end
				end else begin
					len_q <= len_q + 1'b1;
				end
			end
			if (accept && op == OP_POP && count_q != '0) begin
				rd_slot_q <= rd_slot_next;
				count_q   <= count_q - 1'b1;
				drain_n   = drain_n + 1'b1;
			end
			draining_q <= drain_n;
		end
	end

	// keep a copy of the tag characters for the filter
	always_ff @(posedge clk) begin
		if (data_we && len_q >= LW'(TAG_POS) && len_q < LW'(TAG_POS + 4)) begin
			tag_q[2'(len_q - LW'(TAG_POS))] <= rx_byte;
		end
	end

endmodule

/* rtl/nlfq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// nlfq_cmd_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module nlfq_cmd_fifo import nlfq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full       = (fill_q == 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/nlfq_back.sv */
// ----------------------------------------------------------------------------
// nlfq_back
// Carries out queued requests: emits single results or streams a queued
// line from the ring memory through the output register.
// ----------------------------------------------------------------------------
module nlfq_back import nlfq_pkg::*; #(
	parameter int LINE_SIZE   = LINE_SIZE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int SW = $clog2(QUEUE_DEPTH),
	localparam int LW = $clog2(LINE_SIZE),
	localparam int AW = $clog2(QUEUE_DEPTH * LINE_SIZE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	output logic          stream_done,
	output logic          data_re,
	output logic [AW-1:0] data_raddr,
	input  logic [7:0]    data_rdata,
	output logic          len_re,
	output logic [SW-1:0] len_raddr,
	input  logic [LW-1:0] len_rdata,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [1:0]    line_event,
	output logic [7:0]    line_char,
	output logic          last
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_LEN  = 3'b010,
		B_DATA = 3'b100
	} back_state_t;

	back_state_t   state_q, state_d;
	logic [SW-1:0] slot_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] pos_q;
	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [1:0]    event_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic          out_free;
	logic          load;
	logic [1:0]    load_kind;
	logic [1:0]    load_event;
	logic [7:0]    load_char;
	logic          load_last;
	logic          final_byte;
	logic [LW-1:0] rd_pos;

	assign out_free   = !out_valid_q || out_ready;
	assign final_byte = (pos_q == len_q - 1'b1);
	assign len_raddr  = SW'(cmd.slot);
	assign data_raddr = AW'(slot_q) * AW'(LINE_SIZE) + AW'(rd_pos);

	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		stream_done = 1'b0;
		len_re      = 1'b0;
		data_re     = 1'b0;
		rd_pos      = '0;
		load        = 1'b0;
		load_kind   = cmd.kind;
		load_event  = cmd.line_event;
		load_char   = CHAR_NUL;
		load_last   = 1'b1;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					if (cmd.stream) begin
						len_re  = 1'b1;
						cmd_pop = 1'b1;
						state_d = B_LEN;
					end else if (out_free) begin
						load    = 1'b1;
						cmd_pop = 1'b1;
					end
				end
			end
			B_LEN: begin
				data_re = 1'b1;
				state_d = B_DATA;
			end
			B_DATA: begin
				load_kind  = KIND_LINE_BYTE;
				load_event = EV_NONE;
				load_char  = data_rdata;
				load_last  = final_byte;
				if (out_free) begin
					load = 1'b1;
					if (final_byte) begin
						stream_done = 1'b1;
						state_d     = B_IDLE;
					end else begin
						// fetch the next byte while this one goes out
						data_re = 1'b1;
						rd_pos  = pos_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cmd_valid && cmd.stream) begin
			slot_q <= SW'(cmd.slot);
		end
		if (state_q == B_LEN) begin
			len_q <= len_rdata;
			pos_q <= '0;
		end else if (state_q == B_DATA && load && !final_byte) begin
			pos_q <= pos_q + 1'b1;
		end
		if (load) begin
			kind_q  <= load_kind;
			event_q <= load_event;
			char_q  <= load_char;
			last_q  <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign line_event = event_q;
	assign line_char  = char_q;
	assign last       = last_q;

endmodule

/* rtl/nmea_line_filter_queue_core.sv */
// ----------------------------------------------------------------------------
// nmea_line_filter_queue_core
// Assembles serial bytes into NMEA lines, filters tagged lines and queues
// the rest in a ring; pop requests stream the oldest line back out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op = 0 sends one received byte in
//   rx_byte, op = 1 requests the oldest queued line. Output channel
//   (out_valid/out_ready): kind, line_event, line_char and last per result.
//   A byte or an empty pop gives one result with last set; a pop of a queued
//   line gives one result per line character, last on the final one.
//   Throughput: bytes may enter one per cycle while in_ready is high. A pop
//   streams one line byte per cycle while out_ready is high, after the
//   length is read from the length memory and the first character from
//   the ring memory, whose single read port sets that pace. Single results
//   leave through the output register once they pass the two-entry queue.
//   Lines are written straight into the ring, so a commit takes no copy.
//   Input stalls while the request queue is full, or while the slot that
//   would take the next byte is still streaming out a popped line.
//   When the receiver holds out_ready low, the output register keeps its
//   result and the back stops; the front keeps accepting until the queue
//   fills. Reset empties the queue and the line being assembled; the ring
//   memory needs no clearing.
// ----------------------------------------------------------------------------
module nmea_line_filter_queue_core import nlfq_pkg::*; #(
	parameter int LINE_SIZE   = LINE_SIZE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [1:0] line_event,
	output logic [7:0] line_char,
	output logic       last
);

	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(LINE_SIZE);
	localparam int AW = $clog2(QUEUE_DEPTH * LINE_SIZE);

	logic          cmd_full;
	logic          cmd_push;
	cmd_t          cmd_wdata;
	logic          cmd_pop;
	logic          cmd_valid;
	cmd_t          cmd_head;
	logic          stream_done;

	logic          data_we;
	logic [AW-1:0] data_waddr;
	logic [7:0]    data_wdata;
	logic          data_re;
	logic [AW-1:0] data_raddr;
	logic [7:0]    data_rdata;
	logic          len_we;
	logic [SW-1:0] len_waddr;
	logic [LW-1:0] len_wdata;
	logic          len_re;
	logic [SW-1:0] len_raddr;
	logic [LW-1:0] len_rdata;

	nlfq_front #(
		.LINE_SIZE   (LINE_SIZE),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.rx_byte     (rx_byte),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_wdata),
		.stream_done (stream_done),
		.data_we     (data_we),
		.data_waddr  (data_waddr),
		.data_wdata  (data_wdata),
		.len_we      (len_we),
		.len_waddr   (len_waddr),
		.len_wdata   (len_wdata)
	);

	nlfq_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_wdata),
		.full       (cmd_full),
		.pop        (cmd_pop),
		.head_valid (cmd_valid),
		.head       (cmd_head)
	);

	nlfq_ram #(
		.WIDTH (8),
		.DEPTH (QUEUE_DEPTH * LINE_SIZE)
	) u_line_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	nlfq_ram #(
		.WIDTH (LW),
		.DEPTH (QUEUE_DEPTH)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	nlfq_back #(
		.LINE_SIZE   (LINE_SIZE),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd_head),
		.cmd_pop     (cmd_pop),
		.stream_done (stream_done),
		.data_re     (data_re),
		.data_raddr  (data_raddr),
		.data_rdata  (data_rdata),
		.len_re      (len_re),
		.len_raddr   (len_raddr),
		.len_rdata   (len_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.line_event  (line_event),
		.line_char   (line_char),
		.last        (last)
	);

endmodule

/* rtl/nlfq_checker.sv */
// ----------------------------------------------------------------------------
// nlfq_checker
// Port-level checks of the NMEA line filter queue, bound to the top level.
// ----------------------------------------------------------------------------
module nlfq_checker import nlfq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [1:0] line_event,
	input logic [7:0] line_char,
	input logic       last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(line_event)
			&& $stable(line_char) && $stable(last))
		else $error("stalled result changed");

	// only line bytes come in multi-result runs
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_LINE_BYTE |-> last)
		else $error("single result without last");

	// a line stream ends before any other kind of result follows
	a_stream_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_LINE_BYTE && !last
			|=> !out_valid || kind == KIND_LINE_BYTE)
		else $error("line stream interrupted");

	// unused fields stay zero
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_TAKEN || line_event == EV_NONE)
			&& (kind == KIND_LINE_BYTE || line_char == CHAR_NUL))
		else $error("unused result field not zero");

endmodule

bind nmea_line_filter_queue_core nlfq_checker u_nlfq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.line_event (line_event),
	.line_char  (line_char),
	.last       (last)
);
